/* sv/cbmrtc_pkg.sv */
package cbmrtc_pkg;

	// input item modes
	localparam logic [2:0] MODE_ROM_RD  = 3'd0;
	localparam logic [2:0] MODE_ROM_WR  = 3'd1;
	localparam logic [2:0] MODE_RAM_RD  = 3'd2;
	localparam logic [2:0] MODE_RAM_WR  = 3'd3;
	localparam logic [2:0] MODE_TICK    = 3'd4;

	// result targets
	localparam logic [1:0] TGT_NONE = 2'd0;
	localparam logic [1:0] TGT_ROM  = 2'd1;
	localparam logic [1:0] TGT_RAM  = 2'd2;
	localparam logic [1:0] TGT_REG  = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_ROM_SIZE  = 3'd0;
	localparam logic [2:0] CFG_ROM_BANKS = 3'd1;
	localparam logic [2:0] CFG_RAM_SIZE  = 3'd2;
	localparam logic [2:0] CFG_RAM_BANKS = 3'd3;
	localparam logic [2:0] CFG_RTC       = 3'd4;
	localparam logic [2:0] CFG_WIDE_ROM  = 3'd5;

	// ROM-area write regions, address bits 14:13
	localparam logic [1:0] RGN_RAM_EN   = 2'd0;
	localparam logic [1:0] RGN_ROM_BANK = 2'd1;
	localparam logic [1:0] RGN_RAM_BANK = 2'd2;
	localparam logic [1:0] RGN_LATCH    = 2'd3;

	// RAM bank select codes: the last RAM bank, then the clock registers
	localparam logic [7:0] SEL_LAST_RAM = 8'h07;
	localparam logic [7:0] SEL_SEC      = 8'h08;
	localparam logic [7:0] SEL_MIN      = 8'h09;
	localparam logic [7:0] SEL_HOUR     = 8'h0A;
	localparam logic [7:0] SEL_DAY_LO   = 8'h0B;
	localparam logic [7:0] SEL_DAY_HI   = 8'h0C;

	localparam logic [3:0] RAM_EN_KEY = 4'hA;
	localparam logic [7:0] OPEN_BUS   = 8'hFF;
	localparam logic [6:0] SEC_WRAP   = 7'd60;
	localparam logic [6:0] MIN_WRAP   = 7'd60;
	localparam logic [5:0] HOUR_WRAP  = 6'd24;

	typedef struct packed {
		logic [7:0]  rom_sel;
		logic [7:0]  ram_sel;
		logic        ram_en;
		logic [7:0]  latch_last;
		logic [5:0]  sec;
		logic [5:0]  min;
		logic [4:0]  hour;
		logic [8:0]  day;
		logic        halt;
		logic        day_ovf;
		logic [25:0] latched_time;
		logic [1:0]  latched_flags;
	} mapper_st_t;

	localparam mapper_st_t ST_RESET = '{
		rom_sel:       8'd1,
		ram_sel:       8'd0,
		ram_en:        1'b0,
		latch_last:    8'd0,
		sec:           6'd0,
		min:           6'd0,
		hour:          5'd0,
		day:           9'd0,
		halt:          1'b0,
		day_ovf:       1'b0,
		latched_time:  26'd0,
		latched_flags: 2'd0
	};

	typedef struct packed {
		logic [1:0]  target;
		logic [21:0] mem_address;
		logic        mem_write;
		logic [7:0]  read_data;
	} result_t;

endpackage

/* sv/cartridge_bank_mapper_with_rtc_top.sv */
// Latency: an item accepted into the input stage has its result registered in the result register when it advances.
// Throughput: one item per cycle unless the output stalls; a stalled output holds one item in the input stage.
// All mapping and clock carry logic sits between the input stage and the result register.
// Reset (arst_n low, asynchronous): ROM bank 1, all other mapper state and configuration zero,
// no item held.
module cartridge_bank_mapper_with_rtc_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  target,
	output logic [21:0] mem_address,
	output logic        mem_write,
	output logic [7:0]  read_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [22:0] cfg_data
);
	import cbmrtc_pkg::*;

	// configuration
	logic [22:0] rom_bytes_q;
	logic [8:0]  rom_nbanks_q;
	logic [16:0] ram_bytes_q;
	logic [3:0]  ram_nbanks_q;
	logic        rtc_q;
	logic        wide_rom_q;

	// input stage
	logic        valid_s1;
	logic [2:0]  mode_s1;
	logic [15:0] addr_s1;
	logic [7:0]  wdata_s1;

	mapper_st_t st_q, st_d;
	result_t    res_d, res_q;
	logic       out_valid_q;
	logic       adv;

	// combinational helpers
	logic [8:0]  rom_mask;
	logic [7:0]  rom_sel_m;
	logic [21:0] rom_off;
	logic [3:0]  ram_mask;
	logic [2:0]  ram_sel_m;
	logic [15:0] ram_off;
	logic        ram_hit;
	logic        in_ram;
	logic        rtc_sel;
	logic [7:0]  clk_rd;
	logic [7:0]  bank_wr;
	logic [6:0]  sec_inc;
	logic        sec_c;
	logic [6:0]  min_sum;
	logic        min_c;
	logic [5:0]  hour_sum;
	logic        hour_c;
	logic [9:0]  day_sum;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;

	assign out_valid   = out_valid_q;
	assign target      = res_q.target;
	assign mem_address = res_q.mem_address;
	assign mem_write   = res_q.mem_write;
	assign read_data   = res_q.read_data;

	always_comb begin
		rom_mask  = rom_nbanks_q - 9'd1;
		rom_sel_m = (rom_nbanks_q != 9'd0) ? (st_q.rom_sel & rom_mask[7:0]) : st_q.rom_sel;
		rom_off   = addr_s1[14] ? {rom_sel_m, addr_s1[13:0]} : {8'd0, addr_s1[13:0]};

		ram_mask  = ram_nbanks_q - 4'd1;
		ram_sel_m = (ram_nbanks_q != 4'd0) ? (st_q.ram_sel[2:0] & ram_mask[2:0])
		                                   : st_q.ram_sel[2:0];
		ram_off   = {ram_sel_m, addr_s1[12:0]};
		ram_hit   = (ram_bytes_q != 17'd0) && ({1'b0, ram_off} < ram_bytes_q);
		in_ram    = (addr_s1[15:13] == 3'b101);
		rtc_sel   = rtc_q && (st_q.ram_sel <= SEL_DAY_HI);

		case (st_q.ram_sel)
			SEL_SEC:    clk_rd = {2'b00, st_q.latched_time[5:0]};
			SEL_MIN:    clk_rd = {2'b00, st_q.latched_time[11:6]};
			SEL_HOUR:   clk_rd = {3'b000, st_q.latched_time[16:12]};
			SEL_DAY_LO: clk_rd = st_q.latched_time[24:17];
			default:    clk_rd = {st_q.latched_flags[1], st_q.latched_flags[0], 5'd0,
			                      st_q.latched_time[25]};
		endcase

		bank_wr = wide_rom_q ? wdata_s1 : {1'b0, wdata_s1[6:0]};

		// one-second carry chain; each unit can exceed its range by at most one wrap
		sec_inc  = {1'b0, st_q.sec} + 7'd1;
		sec_c    = (sec_inc >= SEC_WRAP);
		min_sum  = {1'b0, st_q.min} + {6'd0, sec_c};
		min_c    = (min_sum >= MIN_WRAP);
		hour_sum = {1'b0, st_q.hour} + {5'd0, min_c};
		hour_c   = (hour_sum >= HOUR_WRAP);
		day_sum  = {1'b0, st_q.day} + {9'd0, hour_c};

		st_d  = st_q;
		res_d = '{target: TGT_NONE, mem_address: 22'd0, mem_write: 1'b0, read_data: 8'd0};

		case (mode_s1)
			MODE_ROM_RD: begin
				if (!addr_s1[15] && ({1'b0, rom_off} < rom_bytes_q)) begin
					res_d.target      = TGT_ROM;
					res_d.mem_address = rom_off;
				end else begin
					res_d.read_data = OPEN_BUS;
				end
			end
			MODE_ROM_WR: begin
				if (!addr_s1[15]) begin
					case (addr_s1[14:13])
						RGN_RAM_EN:   st_d.ram_en = (wdata_s1[3:0] == RAM_EN_KEY);
						RGN_ROM_BANK: st_d.rom_sel = (bank_wr == 8'd0) ? 8'd1 : bank_wr;
						RGN_RAM_BANK: st_d.ram_sel = wdata_s1;
						RGN_LATCH: begin
							if (rtc_q && st_q.latch_last == 8'd0 && wdata_s1 == 8'd1) begin
								st_d.latched_time  = {st_q.day, st_q.hour, st_q.min, st_q.sec};
								st_d.latched_flags = {st_q.day_ovf, st_q.halt};
							end
							st_d.latch_last = wdata_s1;
						end
						default: ;
					endcase
				end
			end
			MODE_RAM_RD: begin
				res_d.read_data = OPEN_BUS;
				if (in_ram && st_q.ram_en) begin
					if (st_q.ram_sel <= SEL_LAST_RAM) begin
						if (ram_hit) begin
							res_d.target      = TGT_RAM;
							res_d.mem_address = {6'd0, ram_off};
							res_d.read_data   = 8'd0;
						end
					end else if (rtc_sel) begin
						res_d.target    = TGT_REG;
						res_d.read_data = clk_rd;
					end
				end
			end
			MODE_RAM_WR: begin
				if (in_ram && st_q.ram_en) begin
					if (st_q.ram_sel <= SEL_LAST_RAM) begin
						if (ram_hit) begin
							res_d.target      = TGT_RAM;
							res_d.mem_address = {6'd0, ram_off};
							res_d.mem_write   = 1'b1;
						end
					end else if (rtc_sel) begin
						case (st_q.ram_sel)
							SEL_SEC:    st_d.sec = wdata_s1[5:0];
							SEL_MIN:    st_d.min = wdata_s1[5:0];
							SEL_HOUR:   st_d.hour = wdata_s1[4:0];
							SEL_DAY_LO: st_d.day = {st_q.day[8], wdata_s1};
							default: begin
								st_d.day     = {wdata_s1[0], st_q.day[7:0]};
								st_d.halt    = wdata_s1[6];
								st_d.day_ovf = wdata_s1[7];
							end
						endcase
					end
				end
			end
			MODE_TICK: begin
				if (rtc_q && !st_q.halt) begin
					st_d.sec  = sec_c ? 6'(sec_inc - SEC_WRAP) : sec_inc[5:0];
					st_d.min  = min_c ? 6'(min_sum - MIN_WRAP) : min_sum[5:0];
					st_d.hour = hour_c ? 5'(hour_sum - HOUR_WRAP) : hour_sum[4:0];
					st_d.day  = day_sum[8:0];
					if (day_sum[9])
						st_d.day_ovf = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bytes_q  <= '0;
			rom_nbanks_q <= '0;
			ram_bytes_q  <= '0;
			ram_nbanks_q <= '0;
			rtc_q        <= 1'b0;
			wide_rom_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROM_SIZE:  rom_bytes_q  <= cfg_data;
				CFG_ROM_BANKS: rom_nbanks_q <= cfg_data[8:0];
				CFG_RAM_SIZE:  ram_bytes_q  <= cfg_data[16:0];
				CFG_RAM_BANKS: ram_nbanks_q <= cfg_data[3:0];
				CFG_RTC:       rtc_q        <= cfg_data[0];
				CFG_WIDE_ROM:  wide_rom_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1  <= mode;
			addr_s1  <= address;
			wdata_s1 <= write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_RESET;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			st_q        <= st_d;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_d;
	end

`ifndef ASSERT_OFF
	a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.rom_sel != 8'd0)
		else $error("ROM bank select is zero");

	a_write_only_ram: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.mem_write |-> res_q.target == TGT_RAM)
		else $error("RAM store flagged on a non-RAM result");

	a_none_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.target == TGT_NONE || res_q.target == TGT_REG)
		|-> res_q.mem_address == 22'd0)
		else $error("mapped offset on a result without external target");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(mode_s1) && $stable(addr_s1))
		else $error("stalled input stage lost its item");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(res_q))
		else $error("stalled result changed");
`endif

endmodule
